// File: rtl/core/lrst_pkg.sv
// Package for the latency running statistics table.
// Holds the item types of both channels and the shared widths and constants.
// Depends on nothing.
package lrst_pkg;

   localparam int ENTRIES_DEF = 256;
   localparam int IDX_W       = 8;
   localparam int LAT_W       = 24;
   localparam int FRAC_W      = 8;
   localparam int WORD_W      = 32;
   localparam int VAR_W       = 56;
   localparam int CFG_W       = 9;

   localparam logic STATUS_UPDATED = 1'b0;
   localparam logic STATUS_UNKNOWN = 1'b1;

   typedef struct packed {
      logic [IDX_W-1:0]  entry_index;
      logic [LAT_W-1:0]  latency_ms;
      logic [WORD_W-1:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [WORD_W-1:0] sample_count;
      logic [WORD_W-1:0] mean_latency;
      logic [WORD_W-1:0] latency_deviation;
      logic [WORD_W-1:0] first_seen;
      logic [WORD_W-1:0] last_seen;
   } rsp_type;

endpackage

// File: rtl/core/lrst_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses no package items.
module lrst_div #(
   parameter int DW = 56,
   parameter int VW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CW = $clog2(DW + 1);

   logic [DW-1:0] q_ff;
   logic [VW-1:0] r_ff;
   logic [VW-1:0] d_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [VW:0]   r_sh;
   logic [VW:0]   r_sub;
   logic          ge;

   assign r_sh  = {r_ff, q_ff[DW-1]};
   assign ge    = r_sh >= {1'b0, d_ff};
   assign r_sub = r_sh - {1'b0, d_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(DW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         q_ff <= dividend;
         r_ff <= '0;
         d_ff <= divisor;
      end else if (busy_ff) begin
         q_ff <= {q_ff[DW-2:0], ge};
         r_ff <= ge ? r_sub[VW-1:0] : r_sh[VW-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

// File: rtl/core/lrst_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Uses no package items.
module lrst_mul #(
   parameter int W = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   op_a,
   input  logic [W-1:0]   op_b,
   output logic           done,
   output logic [2*W-1:0] product
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]   a_ff;
   logic [2*W-1:0] p_ff;
   logic [CW-1:0]  cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic [W:0]     sum;

   assign sum = {1'b0, p_ff[2*W-1:W]} + (p_ff[0] ? {1'b0, a_ff} : {(W+1){1'b0}});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= op_a;
         p_ff <= {{W{1'b0}}, op_b};
      end else if (busy_ff) begin
         p_ff <= {sum, p_ff[W-1:1]};
      end
   end

   assign done    = done_ff;
   assign product = p_ff;
endmodule

// File: rtl/core/lrst_sqrt.sv
// Digit-serial integer square root, two radicand bits per cycle.
// Uses no package items.
module lrst_sqrt #(
   parameter int W = 64
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [W-1:0]   radicand,
   output logic           done,
   output logic [W/2-1:0] root
);
   localparam int HW = W / 2;
   localparam int CW = $clog2(HW + 1);

   logic [W-1:0]  rad_ff;
   logic [HW:0]   rem_ff;
   logic [HW-1:0] root_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;
   logic [HW+2:0] rem_sh;
   logic [HW+2:0] trial;
   logic [HW+2:0] rem_sub;
   logic          ge;

   assign rem_sh  = {rem_ff, rad_ff[W-1:W-2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign ge      = rem_sh >= trial;
   assign rem_sub = rem_sh - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CW'(HW - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[W-3:0], 2'b00};
         rem_ff  <= ge ? rem_sub[HW:0] : rem_sh[HW:0];
         root_ff <= {root_ff[HW-2:0], ge};
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule

// File: rtl/core/latency_running_stats_table_unit.sv
// Top level of the latency running statistics table.
// Depends on lrst_pkg, lrst_div, lrst_mul and lrst_sqrt.
//
// Each item for a known entry updates that table entry with a Welford running
// mean and sample variance and returns count, mean, deviation and seen times;
// an item for an unknown entry returns only an unknown status. One item is in
// work at a time. For a known entry that already holds samples the item passes
// through table read, mean divide, multiply, variance divide, table write,
// square root and response, in that order. The mean divide and the variance
// divide each run 56 serial steps; the multiply and the square root each run
// 32 serial steps. The first sample of an entry skips the divides and the
// multiply, and an unknown entry goes straight from idle to the response
// state. The table resets at once through one valid bit per entry. A finished
// result waits in the output register while the next item is taken. A second
// result waits in the response state until the first has been taken.
module latency_running_stats_table_unit #(
   parameter int ENTRIES = lrst_pkg::ENTRIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  lrst_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output lrst_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [lrst_pkg::CFG_W-1:0]     csr_wr_data
);
   import lrst_pkg::*;

   localparam int DEPTH = (ENTRIES < 256) ? ENTRIES : 256;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [WORD_W-1:0] CNT_MAX = '1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b00000001,
      ST_READ  = 8'b00000010,
      ST_MDIV  = 8'b00000100,
      ST_MUL   = 8'b00001000,
      ST_VDIV  = 8'b00010000,
      ST_WRITE = 8'b00100000,
      ST_SQRT  = 8'b01000000,
      ST_RESP  = 8'b10000000
   } state_type;

   typedef struct packed {
      logic [WORD_W-1:0] count;
      logic [WORD_W-1:0] mean;
      logic [VAR_W-1:0]  variance;
      logic [WORD_W-1:0] first;
      logic [WORD_W-1:0] last;
   } entry_type;

   state_type         state_ff, state_in;
   logic [CFG_W-1:0]  eiu_ff;
   logic [DEPTH-1:0]  vld_ff;
   entry_type         mem [DEPTH];
   entry_type         rd_ff;
   logic              rd_vld_ff;
   logic [AW-1:0]     addr_ff;
   logic              known_ff;
   logic [WORD_W-1:0] x_ff;
   logic [WORD_W-1:0] now_ff;
   logic [WORD_W-1:0] cnt_ff;
   logic [WORD_W-1:0] n_ff;
   logic [WORD_W-1:0] mold_ff;
   logic [WORD_W-1:0] mean_ff;
   logic              mge_ff;
   logic [WORD_W-1:0] bdiff_ff;
   logic [VAR_W-1:0]  var_ff;
   logic              vge_ff;
   logic [WORD_W-1:0] first_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   entry_type         ent;
   logic              accept;
   logic              known;
   logic              wr_en;
   logic [WORD_W:0]   n_wide;
   logic [WORD_W-1:0] n_sat;
   logic [WORD_W-1:0] mdiff;
   logic [WORD_W-1:0] mnew;
   logic [WORD_W-1:0] adiff;
   logic [VAR_W-1:0]  p;
   logic [VAR_W-1:0]  vdiff;
   logic [VAR_W-1:0]  vnew;
   logic              div_start;
   logic [VAR_W-1:0]  div_dividend;
   logic [WORD_W-1:0] div_divisor;
   logic              div_done;
   logic [VAR_W-1:0]  div_q;
   logic              mul_start;
   logic              mul_done;
   logic [2*WORD_W-1:0] mul_p;
   logic              sqrt_start;
   logic              sqrt_done;
   logic [WORD_W-1:0] sqrt_r;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign known     = ({1'b0, req_data.entry_index} < eiu_ff) &&
                      (32'(req_data.entry_index) < ENTRIES);

   assign ent    = rd_vld_ff ? rd_ff : '0;
   assign n_wide = {1'b0, ent.count} + 1'b1;
   assign n_sat  = n_wide[WORD_W] ? CNT_MAX : n_wide[WORD_W-1:0];
   assign mdiff  = (x_ff >= ent.mean) ? x_ff - ent.mean : ent.mean - x_ff;
   assign mnew   = mge_ff ? mold_ff + div_q[WORD_W-1:0] : mold_ff - div_q[WORD_W-1:0];
   assign adiff  = (x_ff >= mnew) ? x_ff - mnew : mnew - x_ff;
   assign p      = mul_p[2*WORD_W-1:FRAC_W];
   assign vdiff  = (p >= var_ff) ? p - var_ff : var_ff - p;
   assign vnew   = vge_ff ? var_ff + div_q : var_ff - div_q;

   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;
      mul_start    = 1'b0;
      sqrt_start   = 1'b0;
      wr_en        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = known ? ST_READ : ST_RESP;
         end
         ST_READ: begin
            if (ent.count == '0) begin
               state_in = ST_WRITE;
            end else begin
               div_start    = 1'b1;
               div_dividend = VAR_W'(mdiff);
               div_divisor  = n_sat;
               state_in     = ST_MDIV;
            end
         end
         ST_MDIV: begin
            if (div_done) begin
               mul_start = 1'b1;
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               div_start    = 1'b1;
               div_dividend = vdiff;
               div_divisor  = n_ff - 1'b1;
               state_in     = ST_VDIV;
            end
         end
         ST_VDIV: begin
            if (div_done) state_in = ST_WRITE;
         end
         ST_WRITE: begin
            wr_en      = 1'b1;
            sqrt_start = 1'b1;
            state_in   = ST_SQRT;
         end
         ST_SQRT: begin
            if (sqrt_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eiu_ff       <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) eiu_ff <= csr_wr_data;
         if (wr_en) vld_ff[addr_ff] <= 1'b1;
         if (state_ff == ST_RESP && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff     <= mem[req_data.entry_index[AW-1:0]];
         rd_vld_ff <= vld_ff[req_data.entry_index[AW-1:0]];
      end
      if (wr_en) begin
         mem[addr_ff] <= '{count: cnt_ff, mean: mean_ff, variance: var_ff,
                           first: first_ff, last: now_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff  <= req_data.entry_index[AW-1:0];
         known_ff <= known;
         x_ff     <= {req_data.latency_ms, {FRAC_W{1'b0}}};
         now_ff   <= req_data.now_seconds;
      end
      case (state_ff)
         ST_READ: begin
            if (ent.count == '0) begin
               cnt_ff   <= 32'd1;
               mean_ff  <= x_ff;
               var_ff   <= '0;
               first_ff <= now_ff;
            end else begin
               cnt_ff   <= n_sat;
               n_ff     <= n_sat;
               mold_ff  <= ent.mean;
               mge_ff   <= x_ff >= ent.mean;
               bdiff_ff <= mdiff;
               var_ff   <= ent.variance;
               first_ff <= ent.first;
            end
         end
         ST_MDIV: begin
            if (div_done) mean_ff <= mnew;
         end
         ST_MUL: begin
            if (mul_done) vge_ff <= p >= var_ff;
         end
         ST_VDIV: begin
            if (div_done) var_ff <= vnew;
         end
         default: ;
      endcase
      if (state_ff == ST_RESP && (!rsp_valid_ff || rsp_ready)) begin
         if (known_ff) begin
            rsp_ff <= '{status: STATUS_UPDATED, sample_count: cnt_ff,
                        mean_latency: mean_ff, latency_deviation: sqrt_r,
                        first_seen: first_ff, last_seen: now_ff};
         end else begin
            rsp_ff <= '{status: STATUS_UNKNOWN, default: '0};
         end
      end
   end

   lrst_div #(.DW(VAR_W), .VW(WORD_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   lrst_mul #(.W(WORD_W)) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (adiff),
      .op_b    (bdiff_ff),
      .done    (mul_done),
      .product (mul_p)
   );

   lrst_sqrt #(.W(2*WORD_W)) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand ({var_ff, {FRAC_W{1'b0}}}),
      .done     (sqrt_done),
      .root     (sqrt_r)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |-> rsp_data.sample_count == '0 &&
      rsp_data.mean_latency == '0 && rsp_data.last_seen == '0)
      else $error("unknown-entry result carries data");

   a_known_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.status |-> rsp_data.sample_count != '0)
      else $error("updated entry reports zero samples");

   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESP))
      else $error("result raised outside the response state");

   a_write_once: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> !wr_en)
      else $error("table written twice for one item");
endmodule
